@@ hdl/rlbp_pkg.sv @@
// ----------------------------------------------------------------------------
// rlbp_pkg
// Shared types, constants and helpers for the replay log byte parser.
// ----------------------------------------------------------------------------
package rlbp_pkg;

	// byte counter width
	localparam int CNT_W = 32;
	localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - CNT_W);

	localparam int HDR_BYTES = 36;
	localparam int CMD_BYTES = 37;
	localparam int CKP_BYTES = 16;

	localparam logic [7:0] MAGIC [8] = '{8'h4C, 8'h43, 8'h52, 8'h45,
		8'h50, 8'h4C, 8'h41, 8'h59};

	// result kinds
	localparam logic [1:0] RK_CMD     = 2'd0;
	localparam logic [1:0] RK_CKPT    = 2'd1;
	localparam logic [1:0] RK_VERDICT = 2'd2;

	// verdict codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SHORT_MAG = 4'd1;
	localparam logic [3:0] ST_BAD_MAG   = 4'd2;
	localparam logic [3:0] ST_SHORT_VER = 4'd3;
	localparam logic [3:0] ST_BAD_VER   = 4'd4;
	localparam logic [3:0] ST_SHORT_SEED = 4'd5;
	localparam logic [3:0] ST_SHORT_CMDN = 4'd6;
	localparam logic [3:0] ST_SHORT_CKPN = 4'd7;
	localparam logic [3:0] ST_MANY_CMD  = 4'd8;
	localparam logic [3:0] ST_MANY_CKPT = 4'd9;
	localparam logic [3:0] ST_BAD_TYPE  = 4'd10;
	localparam logic [3:0] ST_TRAILING  = 4'd11;

	// request passed from front to back
	typedef struct packed {
		logic             last;
		logic             hdr;
		logic [5:0]       pos;
		logic [7:0]       data;
		logic [CNT_W-1:0] total;
	} entry_t;

	// configuration registers
	typedef struct packed {
		logic [31:0] expected_version;
		logic [7:0]  max_command_type;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [63:0] record_tick;
		logic [7:0]  command_code;
		logic [31:0] argument_zero;
		logic [63:0] argument_one;
		logic [63:0] argument_two;
		logic [63:0] issued_tick;
		logic [63:0] state_hash;
		logic [63:0] log_seed;
		logic [3:0]  status;
		logic [63:0] detail_index;
		logic [63:0] detail_count;
	} res_t;

	// replace one byte lane of a 64-bit word
	function automatic logic [63:0] put_byte(input logic [63:0] word,
		input logic [2:0] lane, input logic [7:0] b);
		logic [63:0] w;
		w = word;
		w[lane*8 +: 8] = b;
		return w;
	endfunction

endpackage

@@ hdl/rlbp_queue.sv @@
// ----------------------------------------------------------------------------
// rlbp_queue
// Two-entry queue between the front and back parts of the parser.
// ----------------------------------------------------------------------------
module rlbp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rlbp_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            nempty,
	output rlbp_pkg::entry_t rdata
);
	import rlbp_pkg::*;

	entry_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign nempty = (cnt_q != 2'd0);
	assign rdata  = mem_q[rd_q];

	// store the pushed request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ hdl/rlbp_front.sv @@
// ----------------------------------------------------------------------------
// rlbp_front
// Accepts input items, counts bytes and tags each as header or body.
// ----------------------------------------------------------------------------
module rlbp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic [7:0]       byte_value,
	output logic             push,
	output rlbp_pkg::entry_t wdata,
	input  logic             q_full
);
	import rlbp_pkg::*;

	logic [CNT_W-1:0] bytes_q;
	logic             cnt_full;
	logic             acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign cnt_full = (64'(bytes_q) == CNT_MAX);

	// drop data bytes once the counter is saturated
	assign push = acc && (kind || !cnt_full);

	always_comb begin
		wdata.last  = kind;
		wdata.hdr   = (bytes_q < CNT_W'(HDR_BYTES));
		wdata.pos   = bytes_q[5:0];
		wdata.data  = byte_value;
		wdata.total = bytes_q;
	end

	// count bytes; restart on end of buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
		end else if (acc) begin
			if (kind) bytes_q <= '0;
			else if (!cnt_full) bytes_q <= bytes_q + 1'b1;
		end
	end

endmodule

@@ hdl/rlbp_back.sv @@
// ----------------------------------------------------------------------------
// rlbp_back
// Assembles header fields and records, judges the log, drives results.
// ----------------------------------------------------------------------------
module rlbp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rlbp_pkg::cfg_t   cfg,
	input  logic             q_nempty,
	input  rlbp_pkg::entry_t q_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output rlbp_pkg::res_t   res
);
	import rlbp_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_B    = 2'd1;
	localparam logic [1:0] PH_C    = 2'd2;

	// parser state
	logic             magic_good_q;
	logic [31:0]      version_q;
	logic [63:0]      seed_q;
	logic [63:0]      cmd_cnt_q;
	logic [63:0]      ckp_cnt_q;
	logic [5:0]       offset_q;
	logic [CNT_W-1:0] cmd_done_q;
	logic [CNT_W-1:0] ckp_done_q;
	logic [63:0]      fld_q [5];
	logic             bad_seen_q;
	logic [CNT_W-1:0] bad_idx_q;

	// verdict pipeline
	logic [1:0]       phase_q;
	logic [3:0]       v_status_q;
	logic [63:0]      v_dcount_q;
	logic [63:0]      v_seed_q;
	logic             v_bad_q;
	logic [CNT_W-1:0] v_idx_q;
	logic [CNT_W-1:0] v_rem_q;
	logic             v_cmd_big_s1;
	logic [CNT_W+5:0] v_cmd_prod_s1;
	logic             v_ckp_big_s1;
	logic [CNT_W-1:0] v_ckp_prod_s1;
	logic             v_cmd_fail_s2;
	logic [CNT_W-1:0] v_after_s2;

	logic             out_valid_q;
	res_t             res_q;

	logic             out_free;
	logic             is_end;
	logic             is_body;
	logic             in_cmd;
	logic             in_ckp;
	logic [2:0]       sel;
	logic [5:0]       base;
	logic [2:0]       lane;
	logic [63:0]      nf [5];
	logic             cmd_done_now;
	logic             ckp_done_now;
	logic [3:0]       e_status;
	logic [63:0]      e_dcount;
	logic [CNT_W-1:0] tot;
	logic [CNT_W+5:0] cmd_lo;
	logic             ckp_fail;
	logic [CNT_W-1:0] trail;
	res_t             vres;
	res_t             rec;

	assign out_free  = !out_valid_q || out_ready;
	assign pop       = q_nempty && out_free && (phase_q == PH_IDLE);
	assign is_end    = pop && q_data.last;
	assign is_body   = pop && !q_data.last && !q_data.hdr;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// pick record kind from header counts
	assign in_cmd = (64'(cmd_done_q) < cmd_cnt_q);
	assign in_ckp = !in_cmd && (64'(ckp_done_q) < ckp_cnt_q);

	// place the byte in its record field
	always_comb begin
		if (in_cmd) begin
			if (offset_q < 6'd8) begin
				sel = 3'd0; base = 6'd0;
			end else if (offset_q < 6'd13) begin
				sel = 3'd1; base = 6'd8;
			end else if (offset_q < 6'd21) begin
				sel = 3'd2; base = 6'd13;
			end else if (offset_q < 6'd29) begin
				sel = 3'd3; base = 6'd21;
			end else begin
				sel = 3'd4; base = 6'd29;
			end
		end else begin
			sel  = (offset_q < 6'd8) ? 3'd0 : 3'd1;
			base = (offset_q < 6'd8) ? 6'd0 : 6'd8;
		end
		lane = 3'(offset_q - base);
		for (int i = 0; i < 5; i++) begin
			nf[i] = fld_q[i];
		end
		nf[sel] = put_byte(fld_q[sel], lane, q_data.data);
	end

	assign cmd_done_now = is_body && in_cmd && (offset_q == 6'(CMD_BYTES - 1));
	assign ckp_done_now = is_body && in_ckp && (offset_q == 6'(CKP_BYTES - 1));

	// finished record as a result
	always_comb begin
		rec = '0;
		if (cmd_done_now) begin
			rec.result_kind   = RK_CMD;
			rec.record_tick   = nf[0];
			rec.command_code  = nf[1][7:0];
			rec.argument_zero = nf[1][39:8];
			rec.argument_one  = nf[2];
			rec.argument_two  = nf[3];
			rec.issued_tick   = nf[4];
		end else begin
			rec.result_kind = RK_CKPT;
			rec.record_tick = nf[0];
			rec.state_hash  = nf[1];
		end
	end

	// early verdict from header length and contents
	assign tot = q_data.total;
	always_comb begin
		e_dcount = '0;
		if (tot < CNT_W'(8)) begin
			e_status = ST_SHORT_MAG;
			e_dcount = 64'(tot);
		end else if (!magic_good_q) begin
			e_status = ST_BAD_MAG;
		end else if (tot < CNT_W'(12)) begin
			e_status = ST_SHORT_VER;
		end else if (version_q != cfg.expected_version) begin
			e_status = ST_BAD_VER;
			e_dcount = 64'(version_q);
		end else if (tot < CNT_W'(20)) begin
			e_status = ST_SHORT_SEED;
		end else if (tot < CNT_W'(28)) begin
			e_status = ST_SHORT_CMDN;
		end else if (tot < CNT_W'(HDR_BYTES)) begin
			e_status = ST_SHORT_CKPN;
		end else begin
			e_status = ST_OK;
		end
	end

	// command bytes as count * 37 by shift and add
	assign cmd_lo = (CNT_W+6)'(cmd_cnt_q[CNT_W-1:0]);

	// final verdict checks on the body
	assign ckp_fail = v_ckp_big_s1 || (v_ckp_prod_s1 > v_after_s2);
	assign trail    = v_after_s2 - v_ckp_prod_s1;

	always_comb begin
		vres = '0;
		vres.result_kind = RK_VERDICT;
		vres.log_seed    = v_seed_q;
		if (v_status_q != ST_OK) begin
			vres.status       = v_status_q;
			vres.detail_count = v_dcount_q;
		end else if (v_cmd_fail_s2) begin
			vres.status       = ST_MANY_CMD;
			vres.detail_count = 64'(v_rem_q);
		end else if (ckp_fail) begin
			vres.status       = ST_MANY_CKPT;
			vres.detail_count = 64'(v_after_s2);
		end else if (v_bad_q) begin
			vres.status       = ST_BAD_TYPE;
			vres.detail_index = 64'(v_idx_q);
		end else if (trail != '0) begin
			vres.status       = ST_TRAILING;
			vres.detail_count = 64'(trail);
		end
	end

	// parser state: header, records, clear on end of buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_good_q <= 1'b1;
			version_q    <= '0;
			seed_q       <= '0;
			cmd_cnt_q    <= '0;
			ckp_cnt_q    <= '0;
			offset_q     <= '0;
			cmd_done_q   <= '0;
			ckp_done_q   <= '0;
			bad_seen_q   <= 1'b0;
			bad_idx_q    <= '0;
			for (int i = 0; i < 5; i++) fld_q[i] <= '0;
		end else if (is_end) begin
			magic_good_q <= 1'b1;
			version_q    <= '0;
			seed_q       <= '0;
			cmd_cnt_q    <= '0;
			ckp_cnt_q    <= '0;
			offset_q     <= '0;
			cmd_done_q   <= '0;
			ckp_done_q   <= '0;
			bad_seen_q   <= 1'b0;
			bad_idx_q    <= '0;
			for (int i = 0; i < 5; i++) fld_q[i] <= '0;
		end else if (pop && q_data.hdr) begin
			if (q_data.pos < 6'd8) begin
				if (q_data.data != MAGIC[q_data.pos[2:0]]) magic_good_q <= 1'b0;
			end else if (q_data.pos < 6'd12) begin
				version_q <= 32'(put_byte(64'(version_q), 3'(q_data.pos - 6'd8),
					q_data.data));
			end else if (q_data.pos < 6'd20) begin
				seed_q <= put_byte(seed_q, 3'(q_data.pos - 6'd12), q_data.data);
			end else if (q_data.pos < 6'd28) begin
				cmd_cnt_q <= put_byte(cmd_cnt_q, 3'(q_data.pos - 6'd20), q_data.data);
			end else begin
				ckp_cnt_q <= put_byte(ckp_cnt_q, 3'(q_data.pos - 6'd28), q_data.data);
			end
		end else if (is_body && (in_cmd || in_ckp)) begin
			for (int i = 0; i < 5; i++) fld_q[i] <= nf[i];
			if (cmd_done_now) begin
				offset_q   <= '0;
				cmd_done_q <= cmd_done_q + 1'b1;
				if (nf[1][7:0] > cfg.max_command_type && !bad_seen_q) begin
					bad_seen_q <= 1'b1;
					bad_idx_q  <= cmd_done_q;
				end
			end else if (ckp_done_now) begin
				offset_q   <= '0;
				ckp_done_q <= ckp_done_q + 1'b1;
			end else begin
				offset_q <= offset_q + 1'b1;
			end
		end
	end

	// verdict sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: if (is_end) phase_q <= PH_B;
				PH_B:    phase_q <= PH_C;
				PH_C:    phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// verdict datapath
	always_ff @(posedge clk) begin
		if (is_end) begin
			v_status_q    <= e_status;
			v_dcount_q    <= e_dcount;
			v_seed_q      <= seed_q;
			v_bad_q       <= bad_seen_q;
			v_idx_q       <= bad_idx_q;
			v_rem_q       <= tot - CNT_W'(HDR_BYTES);
			v_cmd_big_s1  <= (cmd_cnt_q > CNT_MAX);
			v_cmd_prod_s1 <= (cmd_lo << 5) + (cmd_lo << 2) + cmd_lo;
			v_ckp_big_s1  <= (ckp_cnt_q > (CNT_MAX >> 4));
			v_ckp_prod_s1 <= {ckp_cnt_q[CNT_W-5:0], 4'b0};
		end
		if (phase_q == PH_B) begin
			v_cmd_fail_s2 <= v_cmd_big_s1 || (v_cmd_prod_s1 > (CNT_W+6)'(v_rem_q));
			v_after_s2    <= v_rem_q - v_cmd_prod_s1[CNT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (phase_q == PH_C) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= cmd_done_now || ckp_done_now;
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_C) begin
			res_q <= vres;
		end else if (cmd_done_now || ckp_done_now) begin
			res_q <= rec;
		end
	end

endmodule

@@ hdl/replay_log_byte_parser.sv @@
// ----------------------------------------------------------------------------
// replay_log_byte_parser
// Byte-serial replay log parser: emits records and one verdict per log.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  input    | in_valid / in_ready     | kind, byte_value
//  output   | out_valid / out_ready   | result_kind .. detail_count
//  config   | APB psel/penable/pready | paddr[2:0], pwdata, prdata
//
// One byte per cycle unless the output stalls or a verdict is pending; a
// record result is registered the cycle after its last byte leaves the queue.
// An end item runs count products, command check and checkpoint check before
// its verdict. Reset clears all but data registers; configuration returns to
// version 1, max type 7. A two-entry queue lets input run while output stalls.
module replay_log_byte_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [63:0] record_tick,
	output logic [7:0]  command_code,
	output logic [31:0] argument_zero,
	output logic signed [63:0] argument_one,
	output logic signed [63:0] argument_two,
	output logic [63:0] issued_tick,
	output logic [63:0] state_hash,
	output logic [63:0] log_seed,
	output logic [3:0]  status,
	output logic [63:0] detail_index,
	output logic [63:0] detail_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rlbp_pkg::*;

	localparam logic REG_VERSION = 1'b0;

	cfg_t   cfg_q;
	entry_t f_data;
	entry_t q_data;
	logic   f_push;
	logic   q_full;
	logic   q_nempty;
	logic   q_pop;
	res_t   res;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= 32'd1;
			cfg_q.max_command_type <= 8'd7;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_VERSION) cfg_q.expected_version <= pwdata;
			else cfg_q.max_command_type <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_VERSION) ? cfg_q.expected_version
		: {24'd0, cfg_q.max_command_type};

	rlbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.byte_value (byte_value),
		.push       (f_push),
		.wdata      (f_data),
		.q_full     (q_full)
	);

	rlbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_data),
		.full   (q_full),
		.pop    (q_pop),
		.nempty (q_nempty),
		.rdata  (q_data)
	);

	rlbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_nempty  (q_nempty),
		.q_data    (q_data),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// unpack the result
	assign result_kind   = res.result_kind;
	assign record_tick   = res.record_tick;
	assign command_code  = res.command_code;
	assign argument_zero = res.argument_zero;
	assign argument_one  = res.argument_one;
	assign argument_two  = res.argument_two;
	assign issued_tick   = res.issued_tick;
	assign state_hash    = res.state_hash;
	assign log_seed      = res.log_seed;
	assign status        = res.status;
	assign detail_index  = res.detail_index;
	assign detail_count  = res.detail_count;

endmodule

@@ tb/rlbp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rlbp_checker
// Watches the byte and result channels of the replay log parser, rebuilds the
// expected records and verdicts from the accepted bytes, and compares them.
// ----------------------------------------------------------------------------
module rlbp_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  logic           kind,
	input  logic [7:0]     byte_value,
	input  logic           out_valid,
	input  logic           out_ready,
	input  rlbp_pkg::res_t seen,
	input  logic [31:0]    cfg_version,
	input  logic [7:0]     cfg_max_type,
	output int             fail_count,
	output int             pending_results
);
	import rlbp_pkg::*;

	res_t        expected_q[$];
	logic [63:0] nbytes;
	logic        magic_ok;
	logic [63:0] ver, seed, ncmd, nckp;
	logic [5:0]  roff;
	logic [63:0] nrec;
	logic [63:0] fld [5];
	logic        badt;
	logic [63:0] badt_idx;

	assign pending_results = expected_q.size();

	function automatic logic [63:0] lane_set(logic [63:0] w, int lane, logic [7:0] b);
		w[lane*8 +: 8] = b;
		return w;
	endfunction

	task automatic clear_log();
		nbytes = 0; magic_ok = 1; ver = 0; seed = 0; ncmd = 0; nckp = 0;
		roff = 0; nrec = 0; badt = 0; badt_idx = 0;
		for (int i = 0; i < 5; i++) fld[i] = 0;
	endtask

	// judge the log: checks run in file order
	function automatic res_t judge_log();
		res_t r;
		logic [63:0] rem, aft;
		r = '0;
		r.result_kind = RK_VERDICT;
		r.log_seed = seed;
		if (nbytes < 8) begin
			r.status = ST_SHORT_MAG; r.detail_count = nbytes;
		end else if (!magic_ok) r.status = ST_BAD_MAG;
		else if (nbytes < 12) r.status = ST_SHORT_VER;
		else if (ver != {32'd0, cfg_version}) begin
			r.status = ST_BAD_VER; r.detail_count = ver;
		end else if (nbytes < 20) r.status = ST_SHORT_SEED;
		else if (nbytes < 28) r.status = ST_SHORT_CMDN;
		else if (nbytes < 36) r.status = ST_SHORT_CKPN;
		else begin
			rem = nbytes - 36;
			if (ncmd > rem / 37) begin
				r.status = ST_MANY_CMD; r.detail_count = rem;
			end else begin
				aft = rem - ncmd * 37;
				if (nckp > aft / 16) begin
					r.status = ST_MANY_CKPT; r.detail_count = aft;
				end else if (badt) begin
					r.status = ST_BAD_TYPE; r.detail_index = badt_idx;
				end else if (aft != nckp * 16) begin
					r.status = ST_TRAILING; r.detail_count = aft - nckp * 16;
				end else r.status = ST_OK;
			end
		end
		return r;
	endfunction

	// advance the parse by one accepted request
	task automatic take_request(logic k, logic [7:0] b);
		res_t r;
		logic [63:0] p;
		r = '0;
		if (k) begin
			expected_q = {expected_q, judge_log()};
			clear_log();
			return;
		end
		if (nbytes >= CNT_MAX) return;
		p = nbytes;
		nbytes++;
		if (p < 36) begin
			if (p < 8) begin
				if (b != MAGIC[p]) magic_ok = 0;
			end else if (p < 12) ver = lane_set(ver, p - 8, b);
			else if (p < 20) seed = lane_set(seed, p - 12, b);
			else if (p < 28) ncmd = lane_set(ncmd, p - 20, b);
			else nckp = lane_set(nckp, p - 28, b);
		end else if (nrec < ncmd) begin
			if (roff < 8) fld[0] = lane_set(fld[0], roff, b);
			else if (roff < 13) fld[1] = lane_set(fld[1], roff - 8, b);
			else if (roff < 21) fld[2] = lane_set(fld[2], roff - 13, b);
			else if (roff < 29) fld[3] = lane_set(fld[3], roff - 21, b);
			else fld[4] = lane_set(fld[4], roff - 29, b);
			roff++;
			if (roff == 37) begin
				r.result_kind = RK_CMD;
				r.record_tick = fld[0];
				r.command_code = fld[1][7:0];
				r.argument_zero = fld[1][39:8];
				r.argument_one = fld[2];
				r.argument_two = fld[3];
				r.issued_tick = fld[4];
				if (fld[1][7:0] > cfg_max_type && !badt) begin
					badt = 1; badt_idx = nrec;
				end
				expected_q = {expected_q, r};
				roff = 0; nrec++;
			end
		end else if (nrec - ncmd < nckp) begin
			if (roff < 8) fld[0] = lane_set(fld[0], roff, b);
			else fld[1] = lane_set(fld[1], roff - 8, b);
			roff++;
			if (roff == 16) begin
				r.result_kind = RK_CKPT;
				r.record_tick = fld[0];
				r.state_hash = fld[1];
				expected_q = {expected_q, r};
				roff = 0; nrec++;
			end
		end
	endtask

	// report one field that differs
	task automatic chk_field(string name, logic [63:0] e, logic [63:0] a);
		if (a !== e) begin
			$error("%s expected %0h actual %0h", name, e, a);
			fail_count++;
		end
	endtask

	task automatic compare_result(res_t a);
		res_t e;
		if (expected_q.size() == 0) begin
			$error("result with nothing expected: kind %0d", a.result_kind);
			fail_count++;
			return;
		end
		e = expected_q.pop_front();
		chk_field("result_kind", 64'(e.result_kind), 64'(a.result_kind));
		chk_field("record_tick", e.record_tick, a.record_tick);
		chk_field("command_code", 64'(e.command_code), 64'(a.command_code));
		chk_field("argument_zero", 64'(e.argument_zero), 64'(a.argument_zero));
		chk_field("argument_one", e.argument_one, a.argument_one);
		chk_field("argument_two", e.argument_two, a.argument_two);
		chk_field("issued_tick", e.issued_tick, a.issued_tick);
		chk_field("state_hash", e.state_hash, a.state_hash);
		chk_field("log_seed", e.log_seed, a.log_seed);
		chk_field("status", 64'(e.status), 64'(a.status));
		chk_field("detail_index", e.detail_index, a.detail_index);
		chk_field("detail_count", e.detail_count, a.detail_count);
	endtask

	initial begin
		fail_count = 0;
		clear_log();
	end

	// sample both channels at each rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) compare_result(seen);
			if (in_valid && in_ready) take_request(kind, byte_value);
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives replay logs, well formed and broken, into the parser under random
// idling on both channels, sets the registers between phases, gives verdict.
// ----------------------------------------------------------------------------
module tb;
	import rlbp_pkg::*;

	localparam logic [2:0] ADDR_VERSION  = 3'd0;
	localparam logic [2:0] ADDR_MAX_TYPE = 3'd4;

	logic        clk = 0, arst_n = 0;
	logic        in_valid = 0, in_ready, kind = 0;
	logic [7:0]  byte_value = 0;
	logic        out_valid, out_ready = 0;
	res_t        res;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic        pready;
	logic [31:0] cur_version = 1;
	logic [7:0]  cur_max_type = 7;
	logic        calm = 0;
	int          fail_count, pending_results;
	int          sent = 0;
	int          cut_list [5] = '{3, 9, 15, 24, 33};

	always #4 clk = ~clk;

	replay_log_byte_parser u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .byte_value(byte_value), .out_valid(out_valid),
		.out_ready(out_ready), .result_kind(res.result_kind),
		.record_tick(res.record_tick), .command_code(res.command_code),
		.argument_zero(res.argument_zero), .argument_one(res.argument_one),
		.argument_two(res.argument_two), .issued_tick(res.issued_tick),
		.state_hash(res.state_hash), .log_seed(res.log_seed), .status(res.status),
		.detail_index(res.detail_index), .detail_count(res.detail_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rlbp_checker u_chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .byte_value(byte_value), .out_valid(out_valid),
		.out_ready(out_ready), .seen(res), .cfg_version(cur_version),
		.cfg_max_type(cur_max_type), .fail_count(fail_count),
		.pending_results(pending_results)
	);

	// result side stalls at random, except in calm stretches
	always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 24);

	// hold valid across back to back requests; drop it only while idling
	task automatic send(logic k, logic [7:0] b);
		while (!calm && $urandom_range(99) < 24) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; kind <= k; byte_value <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_word(logic [63:0] w, int n);
		for (int i = 0; i < n; i++) send(0, w[i*8 +: 8]);
	endtask

	// stop sending and wait for every expected result
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] a, logic [31:0] d);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (a == ADDR_VERSION) cur_version = d;
		else cur_max_type = d[7:0];
		@(posedge clk);
	endtask

	// one log: header, records, then optional damage, then end item
	task automatic send_log(int nc, int nk, int hdr_nc, int hdr_nk, int cut,
		int extra, bit bad_magic, bit bad_ver, bit wild_type);
		logic [7:0] hb [$];
		logic [63:0] w;
		logic [63:0] v;
		v = bad_ver ? {32'd0, cur_version ^ 32'h1} : {32'd0, cur_version};
		for (int i = 0; i < 8; i++) hb = {hb, MAGIC[i]};
		if (bad_magic) hb[$urandom_range(7)] ^= 8'h20;
		for (int i = 0; i < 4; i++) hb = {hb, v[i*8 +: 8]};
		w = {$urandom, $urandom};
		for (int i = 0; i < 8; i++) hb = {hb, w[i*8 +: 8]};
		w = hdr_nc;
		for (int i = 0; i < 8; i++) hb = {hb, w[i*8 +: 8]};
		w = hdr_nk;
		for (int i = 0; i < 8; i++) hb = {hb, w[i*8 +: 8]};
		for (int c = 0; c < nc; c++) begin
			for (int i = 0; i < 37; i++) hb = {hb, 8'($urandom_range(255))};
			hb[hb.size() - 29] = wild_type ? 8'($urandom_range(255)) :
				8'($urandom_range(cur_max_type));
		end
		for (int c = 0; c < nk * 16 + extra; c++) hb = {hb, 8'($urandom_range(255))};
		for (int i = 0; i < hb.size() && (cut < 0 || i < cut); i++) send(0, hb[i]);
		send(1, 8'($urandom_range(255)));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty log, logs cut inside every header field, then damaged logs
		calm = 1;
		send(1, 8'hFF);
		foreach (cut_list[i]) send_log(0, 0, 0, 0, cut_list[i], 0, 0, 0, 0);
		send_log(1, 1, 1, 1, -1, 0, 0, 0, 0);
		send_log(0, 0, 0, 0, -1, 0, 1, 0, 0);
		send_log(0, 0, 0, 0, -1, 0, 0, 1, 0);
		send_log(1, 0, 2, 0, -1, 0, 0, 0, 0);
		send_log(1, 0, 1, 1, -1, 5, 0, 0, 0);
		send_log(1, 1, 1, 1, -1, 3, 0, 0, 0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 8);
		send(1, 0);
		calm = 0;
		drain();

		// random phases across register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin apb_write(ADDR_VERSION, 32'hFFFF_FFFF); apb_write(ADDR_MAX_TYPE, 8'd0); end
				1: begin apb_write(ADDR_VERSION, 32'd0); apb_write(ADDR_MAX_TYPE, 8'd255); end
				2: begin apb_write(ADDR_VERSION, $urandom); apb_write(ADDR_MAX_TYPE, 8'd128); end
				3: begin apb_write(ADDR_VERSION, 32'd1); apb_write(ADDR_MAX_TYPE, 8'd7); end
				default: calm = 1;
			endcase
			while (sent < 500 + 60 * (ph + 1)) begin
				int nc, nk, r;
				nc = $urandom_range(2); nk = $urandom_range(2);
				r = $urandom_range(99);
				if (r < 60) send_log(nc, nk, nc, nk, -1, 0, 0, 0, $urandom_range(1));
				else if (r < 75) send_log(nc, nk, nc + $urandom_range(1), nk, -1,
					$urandom_range(20), 0, 0, 1);
				else if (r < 85) send_log(nc, nk, nc, nk, $urandom_range(80), 0,
					$urandom_range(1), $urandom_range(1), 1);
				else begin
					repeat ($urandom_range(40)) send(0, 8'($urandom_range(255)));
					send(1, 0);
				end
			end
			calm = 0;
			drain();
		end
		drain();
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
